[rtl/core/btmx_pkg.sv]
`default_nettype none

package btmx_pkg;

    localparam int KEY_BITS   = 32;
    localparam int POOL_NODES = 65536;

    localparam int VALUE_W = 31;
    localparam int DATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int CNT_W   = NODE_W + 1;
    localparam int LVL_W   = $clog2(KEY_BITS);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] l1;
        logic [NODE_W-1:0] l0;
    } links_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic stop;
        logic last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/core/btmx_ctrl.sv]
`default_nettype none

module btmx_ctrl import btmx_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.step = 1'b1;
                if (stat.stop || stat.last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.finish = 1'b1;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    in_ready     = 1'b1;
                    if (in_valid) begin
                        cmd.load   = 1'b1;
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/btmx_datapath.sv]
`default_nettype none

module btmx_datapath import btmx_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic               in_op,
    input  logic [VALUE_W-1:0] in_value,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [VALUE_W-1:0] out_xor_max,
    output logic               out_not_found,
    output logic               out_pool_full
);

    links_t link_mem [POOL_NODES];

    logic [KEY_BITS-1:0] key_reg;
    logic                op_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [KEY_BITS-1:0] acc_reg;
    logic                nf_reg;
    logic                pf_reg;
    logic                root_reg;
    logic                fresh_reg;
    links_t              root_links_reg;
    logic [CNT_W-1:0]    nodes_used_reg;
    links_t              rdata_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_xor_reg;
    logic               out_nf_reg;
    logic               out_pf_reg;

    links_t            src;
    links_t            upd;
    logic              key_bit;
    logic [NODE_W-1:0] link_same;
    logic [NODE_W-1:0] link_other;
    logic [NODE_W-1:0] new_node;
    logic [NODE_W-1:0] child;
    logic              hit_same;
    logic              hit_other;
    logic              pool_out;
    logic              is_ins;
    logic              alloc;
    logic              take_other;
    logic              stop;
    logic              mem_we;
    links_t            mem_wdata;

    // fresh nodes read as empty, their memory entry is not yet written
    always_comb begin
        if (root_reg) begin
            src = root_links_reg;
        end else if (fresh_reg) begin
            src = '0;
        end else begin
            src = rdata_reg;
        end
        key_bit    = key_reg[KEY_BITS-1];
        link_same  = key_bit ? src.l1 : src.l0;
        link_other = key_bit ? src.l0 : src.l1;
        hit_same   = link_same != '0;
        hit_other  = link_other != '0;
        pool_out   = nodes_used_reg >= CNT_W'(POOL_NODES);
        is_ins     = op_reg == OP_INSERT;
        alloc      = is_ins && !hit_same && !pool_out;
        take_other = !is_ins && hit_other;
        new_node   = nodes_used_reg[NODE_W-1:0];
        stop       = is_ins ? (!hit_same && pool_out) : (!hit_other && !hit_same);
        if (alloc) begin
            child = new_node;
        end else if (take_other) begin
            child = link_other;
        end else begin
            child = link_same;
        end
        upd = src;
        if (alloc) begin
            if (key_bit) begin
                upd.l1 = new_node;
            end else begin
                upd.l0 = new_node;
            end
        end
        mem_we    = (cmd.step && is_ins && !root_reg && (alloc || fresh_reg))
                  || (cmd.finish && is_ins && fresh_reg);
        mem_wdata = cmd.step ? upd : '0;
    end

    assign stat.stop     = stop;
    assign stat.last     = lvl_reg == '0;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[node_reg] <= mem_wdata;
        end
        rdata_reg <= link_mem[child];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg       <= 1'b0;
            fresh_reg      <= 1'b0;
            root_links_reg <= '0;
            nodes_used_reg <= CNT_W'(1);
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                root_reg  <= 1'b1;
                fresh_reg <= 1'b0;
            end else if (cmd.step) begin
                root_reg <= 1'b0;
                if (alloc) begin
                    fresh_reg      <= 1'b1;
                    nodes_used_reg <= nodes_used_reg + CNT_W'(1);
                    if (root_reg) begin
                        root_links_reg <= upd;
                    end
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg  <= KEY_BITS'(in_value);
            op_reg   <= in_op;
            lvl_reg  <= LVL_W'(KEY_BITS - 1);
            node_reg <= '0;
            acc_reg  <= '0;
            nf_reg   <= 1'b0;
            pf_reg   <= 1'b0;
        end else if (cmd.step) begin
            key_reg <= key_reg << 1;
            lvl_reg <= lvl_reg - LVL_W'(1);
            acc_reg <= {acc_reg[KEY_BITS-2:0], take_other};
            if (stop) begin
                nf_reg <= !is_ins;
                pf_reg <= is_ins;
            end else begin
                node_reg <= child;
            end
        end
        if (cmd.out_load) begin
            out_xor_reg <= nf_reg ? '0 : VALUE_W'(acc_reg);
            out_nf_reg  <= nf_reg;
            out_pf_reg  <= pf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_xor_max   = out_xor_reg;
    assign out_not_found = out_nf_reg;
    assign out_pool_full = out_pf_reg;

    a_pool_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg >= CNT_W'(1) && nodes_used_reg <= CNT_W'(POOL_NODES))
        else $error("node pool count out of range");

    a_query_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> op_reg == OP_INSERT)
        else $error("link memory written by a query");

    a_pool_only_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.step && alloc) |=> $stable(nodes_used_reg))
        else $error("node pool count moved without an allocation");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_nf_reg && out_pf_reg))
        else $error("not_found and pool_full both set");

endmodule

`default_nettype wire

[rtl/core/binary_trie_max_xor_core.sv]
`default_nettype none

// Binary trie holding keys for maximum-XOR queries. Each input beat either inserts its
// key (tuser = 0) or asks for the largest XOR of its key with any stored key (tuser = 1);
// every beat yields exactly one result beat. The trie is walked from the top key bit down,
// one level per clock through the registered read port of the node link memory; an item
// ends early when a query meets a dead end or an insert runs out of pool nodes. A new item
// is taken while the previous result still waits in the output register. Nodes are cleared
// as they are allocated, so there is no clearing pass after reset; an empty trie answers
// not_found and an exhausted pool answers pool_full, leaving the partial path in place.
module binary_trie_max_xor_core import btmx_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,  // value
    input  wire logic [0:0]        s_tuser,  // operation
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [DATA_W-1:0] m_tdata,  // xor_max
    output      logic [1:0]        m_tuser   // pool_full, not_found
);

    cmd_t               cmd;
    stat_t              stat;
    logic [VALUE_W-1:0] xor_max;
    logic               not_found;
    logic               pool_full;

    btmx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    btmx_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_op         (s_tuser[0]),
        .in_value      (s_tdata[VALUE_W-1:0]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_xor_max   (xor_max),
        .out_not_found (not_found),
        .out_pool_full (pool_full)
    );

    assign m_tdata = DATA_W'(xor_max);
    assign m_tuser = {pool_full, not_found};

endmodule

`default_nettype wire
